// ----- rtl/fspa_pkg.sv -----
// Shared types and constants of the fixed-slot pool allocator.
// Used by fspa_ctrl, fspa_dpath and fixed_slot_pool_allocator_unit; depends on nothing.
package fspa_pkg;

	localparam int unsigned DEF_POOL_CAPACITY = 64;
	localparam int unsigned ADDR_W            = 64;
	localparam int unsigned SIZE_W            = 16;
	localparam int unsigned COUNT_W           = 7;
	localparam int unsigned ROW_W             = 32;
	localparam int unsigned BIT_W             = 5;
	localparam int unsigned DIV_CNT_W         = 5;
	localparam int unsigned CFG_IDX_W         = 2;
	localparam int unsigned STATUS_W          = 2;

	localparam logic ACT_ALLOCATE = 1'b0;
	localparam logic ACT_RELEASE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 2'd0,
		ST_FULL         = 2'd1,
		ST_NOT_ACQUIRED = 2'd2,
		ST_BAD_ADDRESS  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POOL_BASE    = 2'd0,
		REG_SLOT_SIZE    = 2'd1,
		REG_SLOTS_IN_USE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic rd;
		logic achk;
		logic mul;
		logic add;
		logic div_step;
		logic rchk;
		logic rupd;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic action;
		logic row_last;
		logic found;
		logic div_last;
		logic bad;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- rtl/fspa_ctrl.sv -----
// Controller state machine of the fixed-slot pool allocator.
// Depends on fspa_pkg; drives the commands of fspa_dpath.
module fspa_ctrl import fspa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_A_MUL,
		S_A_ADD,
		S_DIV,
		S_R_CHK,
		S_R_UPD,
		S_FIN
	} state_t;

	state_t state_q;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_A_RD:  cmd.rd       = 1'b1;
			S_A_CHK: cmd.achk     = 1'b1;
			S_A_MUL: cmd.mul      = 1'b1;
			S_A_ADD: cmd.add      = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_R_CHK: cmd.rchk     = 1'b1;
			S_R_UPD: cmd.rupd     = 1'b1;
			S_FIN:   cmd.out_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (stat.row_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= (stat.action == ACT_RELEASE) ? S_DIV : S_A_RD;
				end
				S_A_RD: state_q <= S_A_CHK;
				S_A_CHK: begin
					if (stat.found) state_q <= S_A_MUL;
					else if (stat.row_last) state_q <= S_FIN;
					else state_q <= S_A_RD;
				end
				S_A_MUL: state_q <= S_A_ADD;
				S_A_ADD: state_q <= S_FIN;
				S_DIV: begin
					if (stat.div_last) state_q <= S_R_CHK;
				end
				S_R_CHK: state_q <= stat.bad ? S_FIN : S_R_UPD;
				S_R_UPD: state_q <= S_FIN;
				S_FIN: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/fspa_dpath.sv -----
// Datapath of the fixed-slot pool allocator: registers, usage-mark memory,
// first-free search, divider, address multiplier and output register. Depends on fspa_pkg.
module fspa_dpath import fspa_pkg::*; #(
	parameter int unsigned POOL_CAPACITY = DEF_POOL_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [ADDR_W-1:0]    wr_data,
	input  logic                 in_action,
	input  logic [ADDR_W-1:0]    in_address,
	output logic [ADDR_W-1:0]    out_address,
	output status_t              out_status,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat
);

	localparam int unsigned ROWS   = (POOL_CAPACITY + ROW_W - 1) / ROW_W;
	localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned SIDX_W = ROW_AW + BIT_W;
	localparam int unsigned CAP_CW = $clog2(POOL_CAPACITY + 1);
	localparam int unsigned CNT_W  = (CAP_CW > COUNT_W) ? CAP_CW : COUNT_W;
	localparam int unsigned CMP_W  = ((SIDX_W > CNT_W) ? SIDX_W : CNT_W) + 1;
	localparam int unsigned PROD_W = SIDX_W + SIZE_W;

	logic [ADDR_W-1:0]  base_q;
	logic [SIZE_W-1:0]  size_q;
	logic [COUNT_W-1:0] count_q;

	logic [ROW_W-1:0]   marks_mem [ROWS];
	logic [ROW_W-1:0]   rd_data_q;
	logic [ROW_AW-1:0]  row_q;
	logic [SIDX_W-1:0]  idx_q;
	logic [PROD_W-1:0]  prod_q;
	logic [ADDR_W-1:0]  dvd_q;
	logic [SIZE_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [ADDR_W-1:0]  res_addr_q;
	status_t            res_status_q;
	logic [ADDR_W-1:0]  out_addr_q;
	status_t            out_status_q;
	logic               out_valid_q;

	logic [SIZE_W-1:0]  size_eff;
	logic [CNT_W-1:0]   cnt_eff;
	logic [ROW_W-1:0]   row_mask;
	logic [ROW_W-1:0]   free_bits;
	logic [ROW_W-1:0]   first_oh;
	logic [BIT_W-1:0]   first_pos;
	logic               found;
	logic               row_last;
	logic [SIZE_W:0]    r1;
	logic [SIZE_W:0]    r2;
	logic               q1;
	logic               q2;
	logic [ROW_AW-1:0]  quo_row;
	logic [BIT_W-1:0]   quo_bit;
	logic [ROW_W-1:0]   quo_oh;
	logic               bad;
	logic               hit;
	logic               mem_we;
	logic [ROW_AW-1:0]  mem_waddr;
	logic [ROW_W-1:0]   mem_wdata;
	logic               mem_re;
	logic [ROW_AW-1:0]  mem_raddr;

	assign size_eff = (size_q == '0) ? SIZE_W'(1) : size_q;
	assign cnt_eff  = (CNT_W'(count_q) > CNT_W'(POOL_CAPACITY)) ? CNT_W'(POOL_CAPACITY)
		: CNT_W'(count_q);
	assign row_last = (row_q == ROW_AW'(ROWS - 1));

	always_comb begin
		for (int b = 0; b < ROW_W; b++) begin
			row_mask[b] = CMP_W'({row_q, BIT_W'(b)}) < CMP_W'(cnt_eff);
		end
		free_bits = ~rd_data_q & row_mask;
		first_oh  = free_bits & (~free_bits + ROW_W'(1));
		first_pos = '0;
		for (int b = 0; b < ROW_W; b++) begin
			if (first_oh[b]) first_pos = first_pos | BIT_W'(b);
		end
		found = |free_bits;
	end

	always_comb begin
		r1 = {rem_q, dvd_q[ADDR_W-1]};
		q1 = (r1 >= {1'b0, size_eff});
		if (q1) r1 = r1 - {1'b0, size_eff};
		r2 = {r1[SIZE_W-1:0], dvd_q[ADDR_W-2]};
		q2 = (r2 >= {1'b0, size_eff});
		if (q2) r2 = r2 - {1'b0, size_eff};
	end

	assign quo_row = dvd_q[SIDX_W-1:BIT_W];
	assign quo_bit = dvd_q[BIT_W-1:0];
	assign quo_oh  = ROW_W'(1) << quo_bit;
	assign bad     = (rem_q != '0) || (dvd_q >= ADDR_W'(cnt_eff));
	assign hit     = rd_data_q[quo_bit];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = row_q;
		mem_wdata = '0;
		if (cmd.clr) begin
			mem_we = 1'b1;
		end else if (cmd.achk && found) begin
			mem_we    = 1'b1;
			mem_wdata = rd_data_q | first_oh;
		end else if (cmd.rupd && hit) begin
			mem_we    = 1'b1;
			mem_waddr = quo_row;
			mem_wdata = rd_data_q & ~quo_oh;
		end
		mem_re    = cmd.rd || (cmd.rchk && !bad);
		mem_raddr = cmd.rchk ? quo_row : row_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) marks_mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_q <= marks_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			size_q      <= SIZE_W'(1);
			count_q     <= COUNT_W'(64);
			row_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				case (cfg_reg_t'(wr_index))
					REG_POOL_BASE:    base_q  <= wr_data;
					REG_SLOT_SIZE:    size_q  <= wr_data[SIZE_W-1:0];
					REG_SLOTS_IN_USE: count_q <= wr_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				row_q     <= '0;
				div_cnt_q <= '0;
			end else if (cmd.clr) begin
				row_q <= row_last ? '0 : row_q + ROW_AW'(1);
			end else if (cmd.achk && !found && !row_last) begin
				row_q <= row_q + ROW_AW'(1);
			end
			if (cmd.div_step) div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q <= in_address - base_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[ADDR_W-3:0], q1, q2};
			rem_q <= r2[SIZE_W-1:0];
		end
		if (cmd.achk && found) idx_q <= {row_q, first_pos};
		if (cmd.mul) prod_q <= PROD_W'(idx_q) * PROD_W'(size_eff);
		if (cmd.add) begin
			res_addr_q   <= base_q + ADDR_W'(prod_q);
			res_status_q <= ST_OK;
		end else if (cmd.achk && !found && row_last) begin
			res_addr_q   <= '0;
			res_status_q <= ST_FULL;
		end else if (cmd.rchk && bad) begin
			res_addr_q   <= '0;
			res_status_q <= ST_BAD_ADDRESS;
		end else if (cmd.rupd) begin
			res_addr_q   <= '0;
			res_status_q <= hit ? ST_OK : ST_NOT_ACQUIRED;
		end
		if (cmd.out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_address   = out_addr_q;
	assign out_status    = out_status_q;
	assign out_valid     = out_valid_q;

	assign stat.action   = in_action;
	assign stat.row_last = row_last;
	assign stat.found    = found;
	assign stat.div_last = (div_cnt_q == '1);
	assign stat.bad      = bad;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

// ----- rtl/fixed_slot_pool_allocator_unit.sv -----
// Top level of the fixed-slot pool allocator.
// Depends on fspa_pkg, fspa_ctrl and fspa_dpath.
//
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/tready        tdata release_address, tuser action
// m_axis    out        m_axis_tvalid/tready        tdata slot_address, tuser status
// config    in         wr_en                       wr_index, wr_data
//
// One item is in work at a time. A release passes through the divider, which resolves two
// quotient bits a cycle, then a check of the address and the update of its usage mark. An allocate
// reads and checks rows of 32 usage marks in turn, then multiplies and adds if a free mark is found.
// After reset a clearing pass over all ceil(POOL_CAPACITY / 32) rows of usage marks runs before the
// first item is taken. A finished item waits in the output register, and the
// next item may be accepted meanwhile.
module fixed_slot_pool_allocator_unit import fspa_pkg::*; #(
	parameter int unsigned POOL_CAPACITY = DEF_POOL_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [ADDR_W-1:0]    wr_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [ADDR_W-1:0]    s_axis_tdata,   // [63:0] release_address
	input  logic                 s_axis_tuser,   // [0] action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [ADDR_W-1:0]    m_axis_tdata,   // [63:0] slot_address
	output logic [STATUS_W-1:0]  m_axis_tuser    // [1:0] status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	status_t  out_status;

	fspa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fspa_dpath #(
		.POOL_CAPACITY (POOL_CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.in_action   (s_axis_tuser),
		.in_address  (s_axis_tdata),
		.out_address (m_axis_tdata),
		.out_status  (out_status),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.cmd         (cmd),
		.stat        (stat)
	);

	assign m_axis_tuser = out_status;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while another is in work");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("output register overwritten before it was taken");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
		else $error("failed item carries a nonzero address");

endmodule

// ----- verif/fspa_slot_checker.sv -----
`timescale 1ns / 1ps
// Checker for fixed_slot_pool_allocator_unit: mirrors the registers and the usage marks,
// predicts the result of every accepted item and compares it with the output channel.
// Depends on fspa_pkg only.
module fspa_slot_checker import fspa_pkg::*; #(
	parameter int unsigned CAPACITY = DEF_POOL_CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [ADDR_W-1:0]    wr_data,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [ADDR_W-1:0]    s_axis_tdata,   // [63:0] release_address
	input  logic                 s_axis_tuser,   // [0] action
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [ADDR_W-1:0]    m_axis_tdata,   // [63:0] slot_address
	input  logic [STATUS_W-1:0]  m_axis_tuser,   // [1:0] status
	output int unsigned          fail_count,
	output int unsigned          outstanding
);

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           status;
	} slot_result_t;

	slot_result_t        expected_slots[$];
	logic [CAPACITY-1:0] usage;
	logic [ADDR_W-1:0]   base_q;
	logic [SIZE_W-1:0]   size_q;
	logic [COUNT_W-1:0]  count_q;
	int unsigned         reported;

	function automatic slot_result_t predict_slot_result(input logic act,
			input logic [ADDR_W-1:0] addr);
		slot_result_t      r;
		logic [ADDR_W-1:0] stride;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] idx;
		int unsigned       limit;
		bit                found;
		stride = (size_q == '0) ? 64'd1 : 64'(size_q);
		limit = (count_q > CAPACITY) ? CAPACITY : int'(count_q);
		r.addr = '0;
		r.status = ST_OK;
		if (act == ACT_ALLOCATE) begin
			found = 1'b0;
			for (int unsigned i = 0; i < limit; i++) begin
				if (!found && !usage[i]) begin
					usage[i] = 1'b1;
					r.addr = base_q + 64'(i) * stride;
					found = 1'b1;
				end
			end
			if (!found) begin
				r.status = ST_FULL;
			end
		end else begin
			offset = addr - base_q;
			idx = offset / stride;
			if ((offset % stride) != '0 || idx >= 64'(limit)) begin
				r.status = ST_BAD_ADDRESS;
			end else if (!usage[idx]) begin
				r.status = ST_NOT_ACQUIRED;
			end else begin
				usage[idx] = 1'b0;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		fail_count++;
		if (reported < 10) begin
			reported++;
			$display("%0t ns: mismatch on %s: expected 0x%h, got 0x%h", $realtime, field,
				want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		slot_result_t oldest;
		if (!arst_n) begin
			usage = '0;
			base_q = '0;
			size_q = 16'd1;
			count_q = 7'd64;
			expected_slots.delete();
			fail_count = 0;
			reported = 0;
			outstanding = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_slots.size() == 0) begin
					report_mismatch("result with none expected", '0, m_axis_tdata);
				end else begin
					oldest = expected_slots.pop_front();
					if (m_axis_tdata !== oldest.addr) begin
						report_mismatch("slot_address", oldest.addr, m_axis_tdata);
					end
					if (m_axis_tuser !== oldest.status) begin
						report_mismatch("status", 64'(oldest.status), 64'(m_axis_tuser));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_slots.push_back(predict_slot_result(s_axis_tuser, s_axis_tdata));
			end
			if (wr_en) begin
				case (cfg_reg_t'(wr_index))
					REG_POOL_BASE: begin
						base_q = wr_data;
					end
					REG_SLOT_SIZE: begin
						size_q = wr_data[SIZE_W-1:0];
					end
					REG_SLOTS_IN_USE: begin
						count_q = wr_data[COUNT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			outstanding = expected_slots.size();
		end
	end

endmodule

// ----- verif/fixed_slot_pool_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for fixed_slot_pool_allocator_unit: clock, reset, register writes, directed
// and random allocate and release items under varying channel throttling, and the verdict.
// Depends on fspa_pkg, fspa_slot_checker and the block itself.
module fixed_slot_pool_allocator_unit_tb;
	import fspa_pkg::*;

	localparam int unsigned CAPACITY        = DEF_POOL_CAPACITY;
	localparam int unsigned PHASES          = 4;
	localparam int unsigned SEGS_PER_PHASE  = 4;
	localparam int unsigned SEGMENT_ITEMS   = 115;
	localparam int unsigned CHUNK_ITEMS     = 40;
	localparam int unsigned CYCLE_LIMIT     = 600000;
	localparam int unsigned HOLD_CYCLES     = 400;
	localparam int unsigned DRAIN_CYCLES    = 50;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [ADDR_W-1:0] ALL_ONES  = {ADDR_W{1'b1}};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [ADDR_W-1:0]    wr_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [ADDR_W-1:0]    s_axis_tdata = '0;   // [63:0] release_address
	logic                 s_axis_tuser = 1'b0; // [0] action
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [ADDR_W-1:0]    m_axis_tdata;        // [63:0] slot_address
	logic [STATUS_W-1:0]  m_axis_tuser;        // [1:0] status

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_len = 0;
	int unsigned hold_left = 0;
	int unsigned cycles = 0;

	logic [ADDR_W-1:0]  cur_base = '0;
	logic [SIZE_W-1:0]  cur_size = 16'd1;
	logic [COUNT_W-1:0] cur_count = 7'd64;

	fixed_slot_pool_allocator_unit #(.POOL_CAPACITY(CAPACITY)) dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	fspa_slot_checker #(.CAPACITY(CAPACITY)) slot_check (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("fixed_slot_pool_allocator_unit_tb: FAIL");
		$finish;
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_len != 0) begin
				hold_left = hold_len;
				hold_len = 0;
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic offer_item(input logic act, input logic [ADDR_W-1:0] addr);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= addr;
		s_axis_tuser <= act;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	task automatic settle_block();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic reconfigure(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
			input logic [COUNT_W-1:0] count);
		settle_block();
		wr_en <= 1'b1;
		wr_index <= REG_POOL_BASE;
		wr_data <= base;
		@(negedge clk);
		wr_index <= REG_SLOT_SIZE;
		wr_data <= {$urandom(), 16'($urandom()), size};
		@(negedge clk);
		wr_index <= REG_SLOTS_IN_USE;
		wr_data <= {$urandom(), 25'($urandom()), count};
		@(negedge clk);
		wr_index <= REG_SPARE;
		wr_data <= {$urandom(), $urandom()};
		@(negedge clk);
		wr_en <= 1'b0;
		cur_base = base;
		cur_size = size;
		cur_count = count;
	endtask

	function automatic logic [ADDR_W-1:0] pick_release_address();
		logic [ADDR_W-1:0] stride;
		int unsigned       limit;
		int unsigned       roll;
		int unsigned       k;
		stride = (cur_size == '0) ? 64'd1 : 64'(cur_size);
		limit = (cur_count > CAPACITY) ? CAPACITY : int'(cur_count);
		roll = $urandom_range(99);
		k = (limit == 0) ? 0 : $urandom_range(limit - 1);
		if (roll < 75) begin
			return cur_base + 64'(k) * stride;
		end else if (roll < 83) begin
			return cur_base + 64'(limit + $urandom_range(3)) * stride;
		end else if (roll < 92) begin
			return cur_base + 64'(k) * stride +
				64'((stride > 1) ? $urandom_range(int'(stride) - 1, 1) : 1);
		end
		return {$urandom(), $urandom()};
	endfunction

	initial begin
		int unsigned send_pcts[PHASES] = '{0, 83, 0, 22};
		int unsigned stall_pcts[PHASES] = '{0, 0, 83, 22};
		int unsigned alloc_pct;
		int unsigned seg;
		logic [ADDR_W-1:0]  base;
		logic [SIZE_W-1:0]  size;
		logic [COUNT_W-1:0] count;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: unit stride, full pool.
		offer_item(ACT_RELEASE, '0);
		offer_item(ACT_RELEASE, ALL_ONES);
		offer_item(ACT_ALLOCATE, ALL_ONES);
		offer_item(ACT_ALLOCATE, '0);
		offer_item(ACT_ALLOCATE, '0);
		offer_item(ACT_RELEASE, 64'd1);
		offer_item(ACT_RELEASE, 64'd1);
		offer_item(ACT_ALLOCATE, '0);
		offer_item(ACT_RELEASE, 64'd64);

		// Widest stride with a base that wraps, and a pool shrunk below its acquired slots.
		reconfigure(64'hFFFF_FFFF_FFFF_0000, 16'hFFFF, 7'd2);
		offer_item(ACT_ALLOCATE, '0);
		offer_item(ACT_RELEASE, 64'hFFFF_FFFF_FFFF_FFFF);
		offer_item(ACT_RELEASE, 64'hFFFF_FFFF_FFFF_0001);
		offer_item(ACT_ALLOCATE, '0);
		offer_item(ACT_RELEASE, 64'hFFFF_FFFF_FFFF_0000 + 64'd2 * 64'hFFFF);

		// Zero slot size and zero slot count.
		reconfigure('0, 16'd0, 7'd0);
		offer_item(ACT_ALLOCATE, '0);
		offer_item(ACT_RELEASE, '0);

		// Slot count above capacity with the highest base.
		reconfigure(ALL_ONES, 16'd0, 7'd127);
		offer_item(ACT_ALLOCATE, '0);
		offer_item(ACT_RELEASE, ALL_ONES + 64'd2);
		offer_item(ACT_RELEASE, ALL_ONES + 64'd64);
		offer_item(ACT_ALLOCATE, '0);

		for (int unsigned p = 0; p < PHASES; p++) begin
			for (int unsigned s = 0; s < SEGS_PER_PHASE; s++) begin
				seg = p * SEGS_PER_PHASE + s;
				case (seg % 3)
					0: base = '0;
					1: base = ALL_ONES;
					default: base = {$urandom(), $urandom()};
				endcase
				case (seg % 4)
					0: size = 16'd1;
					1: size = 16'hFFFF;
					2: size = 16'($urandom_range(64, 2));
					default: size = 16'($urandom_range(65535, 0));
				endcase
				case (seg % 5)
					0: count = 7'd64;
					1: count = 7'd1;
					2: count = 7'd127;
					3: count = 7'($urandom_range(8, 2));
					default: count = 7'($urandom_range(127, 0));
				endcase
				reconfigure(base, size, count);
				send_idle_pct = send_pcts[p];
				stall_pct = stall_pcts[p];
				if (seg == 0) begin
					hold_len = HOLD_CYCLES;
				end
				alloc_pct = 50;
				for (int unsigned n = 0; n < SEGMENT_ITEMS; n++) begin
					if (n % CHUNK_ITEMS == 0) begin
						case ($urandom_range(2))
							0: alloc_pct = 20;
							1: alloc_pct = 50;
							default: alloc_pct = 85;
						endcase
					end
					if ($urandom_range(99) < alloc_pct) begin
						offer_item(ACT_ALLOCATE, {$urandom(), $urandom()});
					end else begin
						offer_item(ACT_RELEASE, pick_release_address());
					end
				end
			end
		end

		settle_block();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("fixed_slot_pool_allocator_unit_tb: PASS");
		end else begin
			$display("fixed_slot_pool_allocator_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/fspa_pkg.sv
rtl/fspa_ctrl.sv
rtl/fspa_dpath.sv
rtl/fixed_slot_pool_allocator_unit.sv
verif/fspa_slot_checker.sv
verif/fixed_slot_pool_allocator_unit_tb.sv
